>>> rtl/core/sensor_send_on_delta_reporter_core_assert.svh
// assertion macros for the send-on-delta reporter checker
`ifndef SENSOR_SEND_ON_DELTA_REPORTER_CORE_ASSERT_SVH
`define SENSOR_SEND_ON_DELTA_REPORTER_CORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SOD_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define SOD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/core/sod_pkg.sv
// package: widths, reset values, codes and the score-to-category map
`timescale 1ns / 1ps

package sod_pkg;

  localparam int TICK_BITS_DEF = 32;

  localparam int CHAN_W     = 4;
  localparam int CO2_W      = 16;
  localparam int DUST_W     = 10;
  localparam int AQI_W      = 10;
  localparam int FILT_W     = 7;
  localparam int CAT_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // channel enable bit positions
  localparam int CH_CO2      = 0;
  localparam int CH_DUST     = 1;
  localparam int CH_CATEGORY = 2;
  localparam int CH_FILTER   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_THRESHOLD       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUST_THRESHOLD      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORT_INTERVAL = 4'd3;

  // register reset values
  localparam logic [CHAN_W-1:0]     CHANNEL_ENABLE_RST = 4'hF;
  localparam logic [CO2_W-1:0]      CO2_THRESHOLD_RST  = 16'd10;
  localparam logic [DUST_W-1:0]     DUST_THRESHOLD_RST = 10'd5;
  localparam logic [CFG_DATA_W-1:0] MAX_INTERVAL_RST   = 32'(30 * 60 * 1000);

  // category codes
  localparam logic [CAT_W-1:0] CAT_GOOD          = 3'd0;
  localparam logic [CAT_W-1:0] CAT_MODERATE      = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SLIGHTLY_BAD  = 3'd2;
  localparam logic [CAT_W-1:0] CAT_UNHEALTHY     = 3'd3;
  localparam logic [CAT_W-1:0] CAT_VERY_BAD      = 3'd4;
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS     = 3'd5;

  // upper score bound of each category, inclusive
  localparam logic [AQI_W-1:0] AQI_GOOD_MAX      = 10'd50;
  localparam logic [AQI_W-1:0] AQI_MODERATE_MAX  = 10'd100;
  localparam logic [AQI_W-1:0] AQI_SLIGHTLY_MAX  = 10'd150;
  localparam logic [AQI_W-1:0] AQI_UNHEALTHY_MAX = 10'd200;
  localparam logic [AQI_W-1:0] AQI_VERY_BAD_MAX  = 10'd300;

  typedef struct packed {
    logic [CHAN_W-1:0]     channel_enable;
    logic [CO2_W-1:0]      co2_threshold;
    logic [DUST_W-1:0]     dust_threshold;
    logic [CFG_DATA_W-1:0] max_report_interval;
  } cfg_t;

  typedef struct packed {
    logic [CO2_W-1:0]  co2_ppm;
    logic [DUST_W-1:0] dust_level;
    logic [AQI_W-1:0]  aqi_score;
    logic [FILT_W-1:0] filter_life;
    logic              send_accepted;
  } sample_t;

  typedef struct packed {
    logic              report_co2;
    logic              report_dust;
    logic              report_category;
    logic              report_filter;
    logic [CO2_W-1:0]  co2_out;
    logic [DUST_W-1:0] dust_out;
    logic [CAT_W-1:0]  category_out;
    logic [FILT_W-1:0] filter_out;
    logic              committed;
  } result_t;

  function automatic logic [CAT_W-1:0] score_to_category(input logic [AQI_W-1:0] s);
    logic [CAT_W-1:0] c;
    if (s <= AQI_GOOD_MAX) begin
      c = CAT_GOOD;
    end else if (s <= AQI_MODERATE_MAX) begin
      c = CAT_MODERATE;
    end else if (s <= AQI_SLIGHTLY_MAX) begin
      c = CAT_SLIGHTLY_BAD;
    end else if (s <= AQI_UNHEALTHY_MAX) begin
      c = CAT_UNHEALTHY;
    end else if (s <= AQI_VERY_BAD_MAX) begin
      c = CAT_VERY_BAD;
    end else begin
      c = CAT_HAZARDOUS;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/sod_if.sv
// channel interfaces: sample input, report output, register writes
`timescale 1ns / 1ps

interface sod_in_if #(
  parameter int TICK_BITS = sod_pkg::TICK_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [TICK_BITS-1:0]         now_tick;
  logic [sod_pkg::CO2_W-1:0]    co2_ppm;
  logic [sod_pkg::DUST_W-1:0]   dust_level;
  logic [sod_pkg::AQI_W-1:0]    aqi_score;
  logic [sod_pkg::FILT_W-1:0]   filter_life;
  logic                         send_accepted;

  modport source (
    output valid, now_tick, co2_ppm, dust_level, aqi_score, filter_life, send_accepted,
    input  ready
  );
  modport sink (
    input  valid, now_tick, co2_ppm, dust_level, aqi_score, filter_life, send_accepted,
    output ready
  );
endinterface

interface sod_out_if;
  logic                       valid;
  logic                       ready;
  logic                       report_co2;
  logic                       report_dust;
  logic                       report_category;
  logic                       report_filter;
  logic [sod_pkg::CO2_W-1:0]  co2_out;
  logic [sod_pkg::DUST_W-1:0] dust_out;
  logic [sod_pkg::CAT_W-1:0]  category_out;
  logic [sod_pkg::FILT_W-1:0] filter_out;
  logic                       committed;

  modport source (
    output valid, report_co2, report_dust, report_category, report_filter,
           co2_out, dust_out, category_out, filter_out, committed,
    input  ready
  );
  modport sink (
    input  valid, report_co2, report_dust, report_category, report_filter,
           co2_out, dust_out, category_out, filter_out, committed,
    output ready
  );
endinterface

interface sod_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sod_pkg::CFG_IDX_W-1:0]  index;
  logic [sod_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/sod_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module sod_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  sod_cfg_if.sink        cfg,
  output sod_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.channel_enable      <= sod_pkg::CHANNEL_ENABLE_RST;
      regs.co2_threshold       <= sod_pkg::CO2_THRESHOLD_RST;
      regs.dust_threshold      <= sod_pkg::DUST_THRESHOLD_RST;
      regs.max_report_interval <= sod_pkg::MAX_INTERVAL_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sod_pkg::REG_CHANNEL_ENABLE: begin
          regs.channel_enable <= cfg.data[sod_pkg::CHAN_W-1:0];
        end
        sod_pkg::REG_CO2_THRESHOLD: begin
          regs.co2_threshold <= cfg.data[sod_pkg::CO2_W-1:0];
        end
        sod_pkg::REG_DUST_THRESHOLD: begin
          regs.dust_threshold <= cfg.data[sod_pkg::DUST_W-1:0];
        end
        sod_pkg::REG_MAX_REPORT_INTERVAL: begin
          regs.max_report_interval <= cfg.data;
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

endmodule

>>> rtl/core/sod_decide.sv
// report decision and last-reported state
`timescale 1ns / 1ps

module sod_decide #(
  parameter int TICK_BITS = sod_pkg::TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sod_pkg::cfg_t        regs,
  input  logic [TICK_BITS-1:0] now_tick,
  input  sod_pkg::sample_t     sample,
  input  logic                 update,
  output sod_pkg::result_t     res
);

  localparam int CMP_W = (TICK_BITS > sod_pkg::CFG_DATA_W) ? TICK_BITS : sod_pkg::CFG_DATA_W;

  logic                         has_reported;
  logic [sod_pkg::CO2_W-1:0]    last_co2;
  logic [sod_pkg::DUST_W-1:0]   last_dust;
  logic [sod_pkg::FILT_W-1:0]   last_filter;
  logic [sod_pkg::CAT_W-1:0]    last_category;
  logic                         category_known;
  logic [TICK_BITS-1:0]         last_report_time;

  logic [TICK_BITS-1:0]         elapsed;
  logic                         force_all;
  logic [sod_pkg::CO2_W-1:0]    co2_diff;
  logic [sod_pkg::DUST_W-1:0]   dust_diff;
  logic [sod_pkg::CAT_W-1:0]    cat;
  logic                         s_co2, s_dust, s_cat, s_filt, commit;

  always_comb begin
    elapsed   = now_tick - last_report_time;
    force_all = !has_reported ||
                (CMP_W'(elapsed) >= CMP_W'(regs.max_report_interval));
    co2_diff  = (sample.co2_ppm >= last_co2) ? sample.co2_ppm - last_co2
                                              : last_co2 - sample.co2_ppm;
    dust_diff = (sample.dust_level >= last_dust) ? sample.dust_level - last_dust
                                                 : last_dust - sample.dust_level;
    cat       = sod_pkg::score_to_category(sample.aqi_score);

    s_co2  = regs.channel_enable[sod_pkg::CH_CO2] &&
             (force_all || co2_diff >= regs.co2_threshold);
    s_dust = regs.channel_enable[sod_pkg::CH_DUST] &&
             (force_all || dust_diff >= regs.dust_threshold);
    // category rides along with co2 or dust
    s_cat  = regs.channel_enable[sod_pkg::CH_CATEGORY] &&
             (force_all || s_co2 || s_dust || !category_known || cat != last_category);
    s_filt = regs.channel_enable[sod_pkg::CH_FILTER] &&
             (force_all || sample.filter_life != last_filter);
    commit = sample.send_accepted && (s_co2 || s_dust || s_cat || s_filt);

    res.report_co2      = s_co2;
    res.report_dust     = s_dust;
    res.report_category = s_cat;
    res.report_filter   = s_filt;
    res.co2_out         = s_co2  ? sample.co2_ppm     : '0;
    res.dust_out        = s_dust ? sample.dust_level  : '0;
    res.category_out    = s_cat  ? cat                : '0;
    res.filter_out      = s_filt ? sample.filter_life : '0;
    res.committed       = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_reported     <= 1'b0;
      last_co2         <= '0;
      last_dust        <= '0;
      last_filter      <= '0;
      last_category    <= sod_pkg::CAT_GOOD;
      category_known   <= 1'b0;
      last_report_time <= '0;
    end else if (update && commit) begin
      if (s_co2) last_co2 <= sample.co2_ppm;
      if (s_dust) last_dust <= sample.dust_level;
      if (s_filt) last_filter <= sample.filter_life;
      if (s_cat) begin
        last_category  <= cat;
        category_known <= 1'b1;
      end
      has_reported     <= 1'b1;
      last_report_time <= now_tick;
    end
  end

endmodule

>>> rtl/core/sensor_send_on_delta_reporter_core.sv
// send-on-delta reporter top level: input register, decision, result register
//
//   channel  dir  carries
//   sample   in   now_tick, co2_ppm, dust_level, aqi_score, filter_life, send_accepted
//   report   out  four channel flags, four values, committed
//   cfg      in   register index and write data, always ready
//
// one sample per cycle sustained while report is not stalled; a transferred sample
// goes into the input register, then the result register, until the report transfers.
// state is read and updated in the decision stage, so each sample sees the
// commit of the one before it. rst (synchronous) clears valid flags, config and state.
// a stalled report holds the result register; the input register still takes one
// sample while it is empty, then sample ready drops until the result register moves.
`timescale 1ns / 1ps

module sensor_send_on_delta_reporter_core #(
  parameter int TICK_BITS = sod_pkg::TICK_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sod_in_if.sink     sample,
  sod_out_if.source  report,
  sod_cfg_if.sink    cfg
);

  sod_pkg::cfg_t        regs;
  logic                 s1_valid;
  logic [TICK_BITS-1:0] s1_tick;
  sod_pkg::sample_t     s1_sample;
  sod_pkg::result_t     dec_res;
  sod_pkg::result_t     out_res;
  logic                 out_valid;
  logic                 out_load;
  logic                 s1_move;

  sod_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sod_decide #(.TICK_BITS(TICK_BITS)) u_decide (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .now_tick (s1_tick),
    .sample   (s1_sample),
    .update   (s1_move),
    .res      (dec_res)
  );

  assign out_load     = !out_valid || report.ready;
  assign s1_move      = s1_valid && out_load;
  assign sample.ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_tick                 <= sample.now_tick;
      s1_sample.co2_ppm       <= sample.co2_ppm;
      s1_sample.dust_level    <= sample.dust_level;
      s1_sample.aqi_score     <= sample.aqi_score;
      s1_sample.filter_life   <= sample.filter_life;
      s1_sample.send_accepted <= sample.send_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= dec_res;
    end
  end

  assign report.valid           = out_valid;
  assign report.report_co2      = out_res.report_co2;
  assign report.report_dust     = out_res.report_dust;
  assign report.report_category = out_res.report_category;
  assign report.report_filter   = out_res.report_filter;
  assign report.co2_out         = out_res.co2_out;
  assign report.dust_out        = out_res.dust_out;
  assign report.category_out    = out_res.category_out;
  assign report.filter_out      = out_res.filter_out;
  assign report.committed       = out_res.committed;

endmodule

>>> rtl/core/sod_checker.sv
// port-level checks on the report channel, bound to the top level
`timescale 1ns / 1ps
`include "sensor_send_on_delta_reporter_core_assert.svh"

module sod_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       valid,
  input logic                       ready,
  input logic                       report_co2,
  input logic                       report_dust,
  input logic                       report_category,
  input logic                       report_filter,
  input logic [sod_pkg::CO2_W-1:0]  co2_out,
  input logic [sod_pkg::DUST_W-1:0] dust_out,
  input logic [sod_pkg::CAT_W-1:0]  category_out,
  input logic [sod_pkg::FILT_W-1:0] filter_out,
  input logic                       committed
);

  localparam int REPORT_W = 4 + sod_pkg::CO2_W + sod_pkg::DUST_W + sod_pkg::CAT_W +
                            sod_pkg::FILT_W + 1;

  logic [REPORT_W-1:0] report_word;
  logic                stalled;
  logic                unsent_zero;
  logic                any_channel;
  logic                cat_in_range;

  assign report_word  = {report_co2, report_dust, report_category, report_filter,
                         co2_out, dust_out, category_out, filter_out, committed};
  assign stalled      = valid && !ready;
  assign unsent_zero  = (report_co2 || co2_out == '0) && (report_dust || dust_out == '0) &&
                        (report_category || category_out == '0) &&
                        (report_filter || filter_out == '0);
  assign any_channel  = report_co2 || report_dust || report_category || report_filter;
  assign cat_in_range = category_out <= sod_pkg::CAT_HAZARDOUS;

  `SOD_ASSERT_NEXT(a_report_hold, stalled, valid && $stable(report_word), "stalled report changed")
  `SOD_ASSERT_NOW(a_unsent_zero, valid, unsent_zero, "value sent for an unreported channel")
  `SOD_ASSERT_NOW(a_commit_nonempty, valid && committed, any_channel, "commit without any channel")
  `SOD_ASSERT_NOW(a_category_range, valid, cat_in_range, "category code out of range")

endmodule

bind sensor_send_on_delta_reporter_core sod_checker u_sod_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (report.valid),
  .ready           (report.ready),
  .report_co2      (report.report_co2),
  .report_dust     (report.report_dust),
  .report_category (report.report_category),
  .report_filter   (report.report_filter),
  .co2_out         (report.co2_out),
  .dust_out        (report.dust_out),
  .category_out    (report.category_out),
  .filter_out      (report.filter_out),
  .committed       (report.committed)
);
